[sv/sts_pkg.sv]
// Shared constants, codes and types for the sorted software timer scheduler.
package sts_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int MAX_FIRE = 16;
   localparam int FIRE_W = $clog2(MAX_FIRE + 1);
   localparam int TIME_W = 48;

   localparam logic [19:0] SLACK_RESET = 20'd500;
   localparam logic [9:0] US_PER_MS = 10'd1000;
   localparam logic [15:0] ID_FIRST = 16'd1;
   localparam logic [15:0] ID_LAST = 16'hFFFF;
   localparam logic [30:0] MS_MAX = 31'h7FFF_FFFF;

   // Wait in microseconds at which the millisecond wait reaches 2^31.
   localparam logic [40:0] WAIT_SAT_US = 41'd2147483648000;
   // 2^20 = 1048 * 1000 + 576.
   localparam logic [10:0] DIV_HI_Q = 11'd1048;
   localparam logic [9:0] DIV_HI_R = 10'd576;
   // ceil(2^35 / 125), exact for dividends below 2^28.
   localparam logic [28:0] DIV_RECIP = 29'd274877907;

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_REMOVE = 3'd1;
   localparam logic [2:0] ACT_UPDATE = 3'd2;
   localparam logic [2:0] ACT_TICK = 3'd3;
   localparam logic [2:0] ACT_QUERY = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_FIRED = 3'd3;
   localparam logic [2:0] ST_NONE = 3'd4;

   typedef enum logic [13:0] {
      S_IDLE       = 14'b00000000000001,
      S_FIND       = 14'b00000000000010,
      S_FIND_DONE  = 14'b00000000000100,
      S_MUL        = 14'b00000000001000,
      S_WRITE      = 14'b00000000010000,
      S_FRONT      = 14'b00000000100000,
      S_FRONT_DONE = 14'b00000001000000,
      S_FIRE       = 14'b00000010000000,
      S_SKIP_SCAN  = 14'b00000100000000,
      S_SKIP_DONE  = 14'b00001000000000,
      S_DIV        = 14'b00010000000000,
      S_DIV_MUL    = 14'b00100000000000,
      S_DIV_DONE   = 14'b01000000000000,
      S_EMIT       = 14'b10000000000000
   } state_type;

endpackage

[sv/sorted_software_timer_scheduler.sv]
// Timer scheduler top level: slot table, sequencer and result register.
// Each transaction is handled by a sequencer that walks the timer slots one per cycle. A remove
// or update first scans the slots for the target id; an update then scales the interval and
// writes the new due time, as does an add. A tick scans for the earliest due timer, fires it,
// rescales and rewrites it if it repeats, and scans again until none is due or MAX_FIRE have
// fired; it then requeues updated timers, one scan each. A query scans for the earliest timer
// and, when one is pending, divides the wait by 1000 with a reciprocal, skipped when the wait
// saturates. Results wait in an output register; while results are stalled the sequencer
// stalls too. The input is ready only when the sequencer is idle.
module sorted_software_timer_scheduler
   import sts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [30:0]        req_interval_ms,
   input  logic               req_repeat_flag,
   input  logic [15:0]        req_target_id,
   input  logic [23:0]        req_elapsed_us,
   input  logic signed [31:0] req_fallback_wait_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_timer_num,
   output logic signed [31:0] rsp_wait_ms,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [19:0]        csr_wr_data
);

   logic [NUM_TIMERS-1:0] slot_valid_ff;
   logic [NUM_TIMERS-1:0] slot_skip_ff;
   logic [15:0]           slot_id_ff [NUM_TIMERS];
   logic [TIME_W-1:0]     slot_due_ff [NUM_TIMERS];
   logic [30:0]           slot_per_ff [NUM_TIMERS];
   logic                  slot_rep_ff [NUM_TIMERS];
   logic [15:0]           slot_ord_ff [NUM_TIMERS];

   state_type state_ff, state_in, after_ff, after_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [15:0] next_id_ff, next_id_in;
   logic [15:0] order_ff, order_in;
   logic [19:0] slack_ff;
   logic [2:0] op_ff, op_in;
   logic [30:0] interval_ff, interval_in;
   logic rep_ff, rep_in;
   logic [15:0] target_ff, target_in;
   logic signed [31:0] fallback_ff, fallback_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic signed [TIME_W-1:0] best_key_ff, best_key_in;
   logic [15:0] best_ord_ff, best_ord_in;
   logic [15:0] best_id_ff, best_id_in;
   logic [30:0] best_per_ff, best_per_in;
   logic best_rep_ff, best_rep_in;
   logic [40:0] prod_ff, prod_in;
   logic [FIRE_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic pend_ff, pend_in;
   logic [15:0] pend_id_ff, pend_id_in;
   logic [40:0] div_x_ff, div_x_in;
   logic [30:0] hq_ff, hq_in;
   logic [30:0] rem_ff, rem_in;
   logic [21:0] qlo_ff, qlo_in;
   logic [2:0] res_status_ff, res_status_in;
   logic [15:0] res_id_ff, res_id_in;
   logic signed [31:0] res_wait_ff, res_wait_in;
   logic res_last_ff, res_last_in;
   logic rsp_valid_ff;
   logic [2:0] rsp_status_ff;
   logic [15:0] rsp_id_ff;
   logic signed [31:0] rsp_wait_ff;
   logic rsp_last_ff;

   logic load;
   logic idx_last;
   logic [IDX_W-1:0] free_idx;
   logic signed [TIME_W-1:0] scan_key;
   logic scan_better;
   logic [30:0] mul_src;
   logic signed [TIME_W:0] wait_us;
   logic [56:0] recip_prod;
   logic [30:0] ms_sat;
   logic [TIME_W-1:0] due_new;

   assign req_ready = (state_ff == S_IDLE);
   assign load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign idx_last = (idx_ff == IDX_W'(NUM_TIMERS - 1));
   assign scan_key = $signed(slot_due_ff[idx_ff] - now_ff);
   assign scan_better = !found_ff || (scan_key < best_key_ff) ||
      ((scan_key == best_key_ff) && (slot_ord_ff[idx_ff] < best_ord_ff));
   assign mul_src = (op_ff == ACT_TICK) ? best_per_ff : interval_ff;
   assign wait_us = $signed({best_key_ff[TIME_W-1], best_key_ff}) +
      $signed({29'd0, slack_ff});
   assign recip_prod = {29'd0, rem_ff[30:3]} * {28'd0, DIV_RECIP};
   assign ms_sat = hq_ff + {9'd0, qlo_ff};
   assign due_new = now_ff + {7'd0, prod_ff};

   always_comb begin
      free_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      now_in = now_ff;
      next_id_in = next_id_ff;
      order_in = order_ff;
      op_in = op_ff;
      interval_in = interval_ff;
      rep_in = rep_ff;
      target_in = target_ff;
      fallback_in = fallback_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      best_idx_in = best_idx_ff;
      best_key_in = best_key_ff;
      best_ord_in = best_ord_ff;
      best_id_in = best_id_ff;
      best_per_in = best_per_ff;
      best_rep_in = best_rep_ff;
      prod_in = prod_ff;
      fire_cnt_in = fire_cnt_ff;
      pend_in = pend_ff;
      pend_id_in = pend_id_ff;
      div_x_in = div_x_ff;
      hq_in = hq_ff;
      rem_in = rem_ff;
      qlo_in = qlo_ff;
      res_status_in = res_status_ff;
      res_id_in = res_id_ff;
      res_wait_in = res_wait_ff;
      res_last_in = res_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_action;
               interval_in = req_interval_ms;
               rep_in = req_repeat_flag;
               target_in = req_target_id;
               fallback_in = req_fallback_wait_ms;
               idx_in = '0;
               found_in = 1'b0;
               res_id_in = '0;
               res_wait_in = '0;
               res_last_in = 1'b1;
               after_in = S_IDLE;
               priority if (req_action == ACT_ADD) begin
                  if (req_interval_ms == '0) begin
                     res_status_in = ST_INVALID;
                     state_in = S_EMIT;
                  end else if (&slot_valid_ff) begin
                     res_status_in = ST_FULL;
                     state_in = S_EMIT;
                  end else begin
                     best_idx_in = free_idx;
                     state_in = S_MUL;
                  end
               end else if (req_action == ACT_REMOVE || req_action == ACT_UPDATE) begin
                  state_in = S_FIND;
               end else if (req_action == ACT_TICK) begin
                  now_in = now_ff + {24'd0, req_elapsed_us};
                  fire_cnt_in = '0;
                  pend_in = 1'b0;
                  state_in = S_FRONT;
               end else if (req_action == ACT_QUERY) begin
                  state_in = S_FRONT;
               end else begin
                  res_status_in = ST_INVALID;
                  state_in = S_EMIT;
               end
            end
         end
         S_FIND: begin
            if (!found_ff && slot_valid_ff[idx_ff] && slot_id_ff[idx_ff] == target_ff) begin
               found_in = 1'b1;
               best_idx_in = idx_ff;
            end
            if (idx_last) begin
               state_in = S_FIND_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FIND_DONE: begin
            after_in = S_IDLE;
            res_last_in = 1'b1;
            res_wait_in = '0;
            if (!found_ff || (op_ff == ACT_UPDATE && interval_ff == '0)) begin
               res_status_in = ST_INVALID;
               res_id_in = '0;
               state_in = S_EMIT;
            end else if (op_ff == ACT_REMOVE) begin
               res_status_in = ST_OK;
               res_id_in = target_ff;
               state_in = S_EMIT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = mul_src * US_PER_MS;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            res_status_in = ST_OK;
            res_wait_in = '0;
            res_last_in = 1'b1;
            after_in = S_IDLE;
            priority if (op_ff == ACT_ADD) begin
               order_in = order_ff + 1'b1;
               next_id_in = (next_id_ff == ID_LAST) ? ID_FIRST : next_id_ff + 1'b1;
               res_id_in = next_id_ff;
               state_in = S_EMIT;
            end else if (op_ff == ACT_UPDATE) begin
               res_id_in = target_ff;
               state_in = S_EMIT;
            end else begin
               order_in = order_ff + 1'b1;
               idx_in = '0;
               found_in = 1'b0;
               state_in = S_FRONT;
            end
         end
         S_FRONT: begin
            if (slot_valid_ff[idx_ff] && !slot_skip_ff[idx_ff] && scan_better) begin
               found_in = 1'b1;
               best_idx_in = idx_ff;
               best_key_in = scan_key;
               best_ord_in = slot_ord_ff[idx_ff];
               best_id_in = slot_id_ff[idx_ff];
               best_per_in = slot_per_ff[idx_ff];
               best_rep_in = slot_rep_ff[idx_ff];
            end
            if (idx_last) begin
               state_in = S_FRONT_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FRONT_DONE: begin
            res_wait_in = '0;
            if (op_ff == ACT_TICK) begin
               if (found_ff && !(best_key_ff > $signed({28'd0, slack_ff})) &&
                   fire_cnt_ff != FIRE_W'(MAX_FIRE)) begin
                  if (pend_ff) begin
                     res_status_in = ST_FIRED;
                     res_id_in = pend_id_ff;
                     res_last_in = 1'b0;
                     after_in = S_FIRE;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_FIRE;
                  end
               end else begin
                  res_status_in = pend_ff ? ST_FIRED : ST_NONE;
                  res_id_in = pend_ff ? pend_id_ff : 16'd0;
                  res_last_in = 1'b1;
                  idx_in = '0;
                  found_in = 1'b0;
                  after_in = S_SKIP_SCAN;
                  state_in = S_EMIT;
               end
            end else begin
               res_status_in = ST_OK;
               res_id_in = '0;
               res_last_in = 1'b1;
               after_in = S_IDLE;
               if (!found_ff) begin
                  res_wait_in = fallback_ff;
                  state_in = S_EMIT;
               end else if (wait_us[TIME_W] || wait_us == '0) begin
                  state_in = S_EMIT;
               end else if (wait_us[TIME_W-1:0] >= {7'd0, WAIT_SAT_US}) begin
                  hq_in = MS_MAX;
                  qlo_in = '0;
                  state_in = S_DIV_DONE;
               end else begin
                  div_x_in = wait_us[40:0];
                  state_in = S_DIV;
               end
            end
         end
         S_FIRE: begin
            pend_in = 1'b1;
            pend_id_in = best_id_ff;
            fire_cnt_in = fire_cnt_ff + 1'b1;
            if (best_rep_ff) begin
               state_in = S_MUL;
            end else begin
               idx_in = '0;
               found_in = 1'b0;
               state_in = S_FRONT;
            end
         end
         S_SKIP_SCAN: begin
            if (slot_valid_ff[idx_ff] && slot_skip_ff[idx_ff] &&
                (!found_ff || slot_id_ff[idx_ff] < best_id_ff)) begin
               found_in = 1'b1;
               best_idx_in = idx_ff;
               best_id_in = slot_id_ff[idx_ff];
            end
            if (idx_last) begin
               state_in = S_SKIP_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SKIP_DONE: begin
            if (found_ff) begin
               order_in = order_ff + 1'b1;
               idx_in = '0;
               found_in = 1'b0;
               state_in = S_SKIP_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            hq_in = {10'd0, div_x_ff[40:20]} * {20'd0, DIV_HI_Q};
            rem_in = {10'd0, div_x_ff[40:20]} * {21'd0, DIV_HI_R} + {11'd0, div_x_ff[19:0]};
            state_in = S_DIV_MUL;
         end
         S_DIV_MUL: begin
            qlo_in = recip_prod[56:35];
            state_in = S_DIV_DONE;
         end
         S_DIV_DONE: begin
            if (ms_sat == '0) begin
               res_wait_in = '0;
            end else if (fallback_ff[31] || $signed({1'b0, ms_sat}) < fallback_ff) begin
               res_wait_in = $signed({1'b0, ms_sat});
            end else begin
               res_wait_in = fallback_ff;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (load) begin
               state_in = after_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         after_ff <= S_IDLE;
         now_ff <= '0;
         next_id_ff <= ID_FIRST;
         order_ff <= '0;
         slack_ff <= SLACK_RESET;
         slot_valid_ff <= '0;
         slot_skip_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         now_ff <= now_in;
         next_id_ff <= next_id_in;
         order_ff <= order_in;
         if (csr_wr_en) begin
            slack_ff <= csr_wr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_WRITE: begin
               if (op_ff == ACT_ADD) begin
                  slot_valid_ff[best_idx_ff] <= 1'b1;
                  slot_skip_ff[best_idx_ff] <= 1'b0;
               end else if (op_ff == ACT_UPDATE) begin
                  slot_skip_ff[best_idx_ff] <= 1'b1;
               end
            end
            S_FIND_DONE: begin
               if (found_ff && op_ff == ACT_REMOVE) begin
                  slot_valid_ff[best_idx_ff] <= 1'b0;
                  slot_skip_ff[best_idx_ff] <= 1'b0;
               end
            end
            S_FIRE: begin
               if (!best_rep_ff) begin
                  slot_valid_ff[best_idx_ff] <= 1'b0;
               end
            end
            S_SKIP_DONE: begin
               if (found_ff) begin
                  slot_skip_ff[best_idx_ff] <= 1'b0;
               end else begin
                  slot_skip_ff <= slot_skip_ff & slot_valid_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      interval_ff <= interval_in;
      rep_ff <= rep_in;
      target_ff <= target_in;
      fallback_ff <= fallback_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      best_ord_ff <= best_ord_in;
      best_id_ff <= best_id_in;
      best_per_ff <= best_per_in;
      best_rep_ff <= best_rep_in;
      prod_ff <= prod_in;
      fire_cnt_ff <= fire_cnt_in;
      pend_ff <= pend_in;
      pend_id_ff <= pend_id_in;
      div_x_ff <= div_x_in;
      hq_ff <= hq_in;
      rem_ff <= rem_in;
      qlo_ff <= qlo_in;
      res_status_ff <= res_status_in;
      res_id_ff <= res_id_in;
      res_wait_ff <= res_wait_in;
      res_last_ff <= res_last_in;
      if (load) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff <= res_id_ff;
         rsp_wait_ff <= res_wait_ff;
         rsp_last_ff <= res_last_ff;
      end
      if (state_ff == S_WRITE) begin
         slot_due_ff[best_idx_ff] <= due_new;
         if (op_ff == ACT_ADD) begin
            slot_id_ff[best_idx_ff] <= next_id_ff;
            slot_per_ff[best_idx_ff] <= interval_ff;
            slot_rep_ff[best_idx_ff] <= rep_ff;
            slot_ord_ff[best_idx_ff] <= order_ff;
         end else if (op_ff == ACT_UPDATE) begin
            slot_per_ff[best_idx_ff] <= interval_ff;
         end else begin
            slot_ord_ff[best_idx_ff] <= order_ff;
         end
      end
      if (state_ff == S_SKIP_DONE && found_ff) begin
         slot_ord_ff[best_idx_ff] <= order_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_timer_num = rsp_id_ff;
   assign rsp_wait_ms = rsp_wait_ff;
   assign rsp_last = rsp_last_ff;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the sorted software timer scheduler.
`timescale 1ns / 100ps

module testbench
   import sts_pkg::*;
();

   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [19:0] SLACK_MAX = 20'd1000000;
   localparam int TAIL_CYCLES = 400;

   typedef struct packed {
      logic [2:0] status;
      logic [15:0] timer_num;
      logic signed [31:0] wait_ms;
      logic last;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_action = '0;
   logic [30:0] req_interval_ms = '0;
   logic req_repeat_flag = 0;
   logic [15:0] req_target_id = '0;
   logic [23:0] req_elapsed_us = '0;
   logic signed [31:0] req_fallback_wait_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [2:0] rsp_status;
   logic [15:0] rsp_timer_num;
   logic signed [31:0] rsp_wait_ms;
   logic rsp_last;
   logic csr_wr_en = 0;
   logic [19:0] csr_wr_data = '0;

   // Predicted scheduler state.
   bit tmr_valid [NUM_TIMERS];
   bit tmr_skip [NUM_TIMERS];
   bit tmr_repeat [NUM_TIMERS];
   logic [15:0] tmr_id [NUM_TIMERS];
   logic [47:0] tmr_due [NUM_TIMERS];
   logic [30:0] tmr_period [NUM_TIMERS];
   logic [15:0] tmr_stamp [NUM_TIMERS];
   logic [47:0] now_us = '0;
   logic [15:0] next_id = ID_FIRST;
   logic [15:0] stamp_count = '0;
   logic [19:0] slack_us = SLACK_RESET;

   result_type awaited_results [$];
   bit quiet = 0;
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int fired_seen = 0;
   int slack_writes = 0;

   sorted_software_timer_scheduler DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_interval_ms(req_interval_ms), .req_repeat_flag(req_repeat_flag),
      .req_target_id(req_target_id), .req_elapsed_us(req_elapsed_us),
      .req_fallback_wait_ms(req_fallback_wait_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_timer_num(rsp_timer_num), .rsp_wait_ms(rsp_wait_ms), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic longint time_to_due(int i);
      logic [47:0] d;
      d = tmr_due[i] - now_us;
      return {{16{d[47]}}, d};
   endfunction

   function automatic logic [15:0] next_stamp();
      logic [15:0] s;
      s = stamp_count;
      stamp_count = stamp_count + 16'd1;
      return s;
   endfunction

   function automatic int earliest_slot();
      int best;
      longint bk;
      longint k;
      best = -1;
      bk = 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (tmr_valid[i] && !tmr_skip[i]) begin
            k = time_to_due(i);
            if (best < 0 || k < bk || (k == bk && tmr_stamp[i] < tmr_stamp[best])) begin
               best = i;
               bk = k;
            end
         end
      end
      return best;
   endfunction

   function automatic int slot_of_id(logic [15:0] id);
      for (int i = 0; i < NUM_TIMERS; i++)
         if (tmr_valid[i] && tmr_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void queue_result(logic [2:0] st, logic [15:0] id,
                                        logic signed [31:0] w, logic lst);
      result_type r;
      r.status = st;
      r.timer_num = id;
      r.wait_ms = w;
      r.last = lst;
      awaited_results.insert(awaited_results.size(), r);
   endfunction

   function automatic void schedule_transaction(logic [2:0] act, logic [30:0] ival, logic rep,
                                                logic [15:0] target, logic [23:0] elapsed,
                                                logic signed [31:0] fb);
      int s;
      int n;
      longint t;
      longint ms;
      longint w;
      longint fbl;
      fbl = fb;
      case (act)
         ACT_ADD: begin
            s = -1;
            for (int i = NUM_TIMERS - 1; i >= 0; i--) if (!tmr_valid[i]) s = i;
            if (ival == 0) queue_result(ST_INVALID, 0, 0, 1);
            else if (s < 0) queue_result(ST_FULL, 0, 0, 1);
            else begin
               tmr_valid[s] = 1;
               tmr_id[s] = next_id;
               tmr_due[s] = now_us + ival * 48'd1000;
               tmr_period[s] = ival;
               tmr_repeat[s] = rep;
               tmr_stamp[s] = next_stamp();
               tmr_skip[s] = 0;
               queue_result(ST_OK, next_id, 0, 1);
               next_id = (next_id == ID_LAST) ? ID_FIRST : next_id + 16'd1;
            end
         end
         ACT_REMOVE, ACT_UPDATE: begin
            s = slot_of_id(target);
            if (s < 0 || (act == ACT_UPDATE && ival == 0)) queue_result(ST_INVALID, 0, 0, 1);
            else begin
               if (act == ACT_REMOVE) begin
                  tmr_valid[s] = 0;
                  tmr_skip[s] = 0;
               end else begin
                  tmr_period[s] = ival;
                  tmr_due[s] = now_us + ival * 48'd1000;
                  tmr_skip[s] = 1;
               end
               queue_result(ST_OK, target, 0, 1);
            end
         end
         ACT_TICK: begin
            n = 0;
            now_us = now_us + elapsed;
            while (n < MAX_FIRE) begin
               s = earliest_slot();
               if (s < 0 || time_to_due(s) > longint'(slack_us)) break;
               queue_result(ST_FIRED, tmr_id[s], 0, 0);
               n++;
               if (tmr_repeat[s]) begin
                  tmr_due[s] = now_us + tmr_period[s] * 48'd1000;
                  tmr_stamp[s] = next_stamp();
               end else tmr_valid[s] = 0;
            end
            forever begin
               s = -1;
               for (int i = 0; i < NUM_TIMERS; i++)
                  if (tmr_valid[i] && tmr_skip[i] && (s < 0 || tmr_id[i] < tmr_id[s])) s = i;
               if (s < 0) break;
               tmr_skip[s] = 0;
               tmr_stamp[s] = next_stamp();
            end
            for (int i = 0; i < NUM_TIMERS; i++) if (!tmr_valid[i]) tmr_skip[i] = 0;
            if (n == 0) queue_result(ST_NONE, 0, 0, 1);
            else awaited_results[$].last = 1;
         end
         ACT_QUERY: begin
            s = earliest_slot();
            if (s < 0) w = fbl;
            else begin
               t = time_to_due(s) + longint'(slack_us);
               ms = (t > 0) ? t / 1000 : 0;
               if (ms > longint'(MS_MAX)) ms = MS_MAX;
               if (ms <= 0) w = 0;
               else if (fbl < 0 || ms < fbl) w = ms;
               else w = fbl;
            end
            queue_result(ST_OK, 0, w[31:0], 1);
         end
         default: queue_result(ST_INVALID, 0, 0, 1);
      endcase
   endfunction

   task automatic send_item(logic [2:0] act, logic [30:0] ival, logic rep, logic [15:0] target,
                            logic [23:0] elapsed, logic signed [31:0] fb);
      while (!quiet && $urandom_range(99) < 19) @(negedge clock);
      req_action = act;
      req_interval_ms = ival;
      req_repeat_flag = rep;
      req_target_id = target;
      req_elapsed_us = elapsed;
      req_fallback_wait_ms = fb;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      schedule_transaction(act, ival, rep, target, elapsed, fb);
      items_sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic drain();
      while (awaited_results.size() != 0) @(negedge clock);
   endtask

   task automatic set_slack(logic [19:0] v);
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 0;
      slack_us = v;
      slack_writes++;
   endtask

   task automatic remove_all();
      for (int i = 0; i < NUM_TIMERS; i++)
         if (tmr_valid[i]) send_item(ACT_REMOVE, 0, 0, tmr_id[i], 0, 0);
   endtask

   task automatic test_directed();
      send_item(ACT_ADD, 0, 0, 0, 0, 0);
      send_item(ACT_ADD, 1, 0, 0, 0, 0);
      send_item(ACT_ADD, MS_MAX, 1, 0, 0, 0);
      send_item(ACT_ADD, 5, 1, 0, 0, 0);
      send_item(ACT_QUERY, 0, 0, 0, 0, -1);
      send_item(ACT_QUERY, 0, 0, 0, 0, 0);
      send_item(ACT_QUERY, 0, 0, 0, 0, 32'sh7FFF_FFFF);
      send_item(ACT_UPDATE, 3, 0, 16'd1, 0, 0);
      send_item(ACT_UPDATE, 3, 0, 16'hFFFF, 0, 0);
      send_item(ACT_UPDATE, 0, 0, 16'd2, 0, 0);
      send_item(ACT_QUERY, 0, 0, 0, 0, 100);
      send_item(ACT_TICK, 0, 0, 0, 0, 0);
      send_item(ACT_QUERY, 0, 0, 0, 0, -1);
      send_item(ACT_TICK, 0, 0, 0, 24'hFF_FFFF, 0);
      send_item(ACT_TICK, 0, 0, 0, 24'd1, 0);
      send_item(ACT_REMOVE, 0, 0, 16'd0, 0, 0);
      send_item(ACT_REMOVE, 0, 0, 16'd2, 0, 0);
      send_item(ACT_REMOVE, 0, 0, 16'd2, 0, 0);
      for (logic [3:0] a = ACT_UNUSED_FIRST; a <= 7; a++)
         send_item(a[2:0], MS_MAX, 1, 16'hFFFF, 24'hFF_FFFF, -1);
      send_item(ACT_QUERY, 0, 0, 0, 0, 32'sh8000_0000);
      remove_all();
   endtask

   task automatic test_full_table();
      set_slack(SLACK_MAX);
      for (int i = 0; i <= NUM_TIMERS; i++) send_item(ACT_ADD, 1, 1'(i % 2), 0, 0, 0);
      send_item(ACT_TICK, 0, 0, 0, 24'd1000, 0);
      send_item(ACT_TICK, 0, 0, 0, 24'd0, 0);
      send_item(ACT_QUERY, 0, 0, 0, 0, 7);
      remove_all();
      set_slack(20'd0);
      send_item(ACT_ADD, 2, 0, 0, 0, 0);
      send_item(ACT_ADD, 2, 1, 0, 0, 0);
      send_item(ACT_QUERY, 0, 0, 0, 0, -1);
      send_item(ACT_TICK, 0, 0, 0, 24'd1999, 0);
      send_item(ACT_TICK, 0, 0, 0, 24'd1, 0);
      remove_all();
   endtask

   task automatic test_random();
      int sel;
      int live [$];
      logic [30:0] ival;
      logic [15:0] target;
      logic [23:0] elapsed;
      for (int n = 0; n < 390; n++) begin
         quiet = (n >= 150 && n < 230);
         if (n == 100) set_slack(20'($urandom_range(SLACK_MAX)));
         if (n == 300) begin
            drain();
            set_slack(20'($urandom_range(2000)));
         end
         live.delete();
         for (int i = 0; i < NUM_TIMERS; i++)
            if (tmr_valid[i]) live.insert(live.size(), int'(tmr_id[i]));
         sel = $urandom_range(99);
         ival = ($urandom_range(19) == 0) ? 31'($urandom) : 31'($urandom_range(40));
         target = (live.size() != 0 && $urandom_range(9) != 0) ?
                  16'(live[$urandom_range(live.size() - 1)]) : 16'($urandom);
         elapsed = ($urandom_range(15) == 0) ? 24'($urandom) : 24'($urandom_range(30000));
         if (sel < 30) send_item(ACT_ADD, ival, 1'($urandom_range(1)), target, elapsed,
                                 $urandom);
         else if (sel < 45) send_item(ACT_REMOVE, ival, 1'($urandom_range(1)), target, elapsed,
                                      $urandom);
         else if (sel < 57) send_item(ACT_UPDATE, ival, 1'($urandom_range(1)), target, elapsed,
                                      $urandom);
         else if (sel < 82) send_item(ACT_TICK, ival, 1'($urandom_range(1)), target, elapsed,
                                      $urandom);
         else if (sel < 96) send_item(ACT_QUERY, ival, 1'($urandom_range(1)), target, elapsed,
                                      ($urandom_range(3) == 0) ? -1 : int'($urandom));
         else send_item(3'($urandom_range(7, ACT_UNUSED_FIRST)), ival, 1'($urandom_range(1)),
                        target, elapsed, $urandom);
      end
      quiet = 0;
   endtask

   always @(negedge clock) rsp_ready <= quiet || ($urandom_range(99) >= 19);

   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_status == ST_FIRED) fired_seen++;
         if (awaited_results.size() == 0) begin
            $error("unexpected result status %0d timer_num %0d", rsp_status, rsp_timer_num);
            errors++;
         end else begin
            exp_r = awaited_results[0];
            awaited_results.delete(0);
            if (rsp_status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_status);
               errors++;
            end
            if (rsp_timer_num !== exp_r.timer_num) begin
               $error("timer_num expected %0d actual %0d", exp_r.timer_num, rsp_timer_num);
               errors++;
            end
            if (rsp_wait_ms !== exp_r.wait_ms) begin
               $error("wait_ms expected %0d actual %0d", exp_r.wait_ms, rsp_wait_ms);
               errors++;
            end
            if (rsp_last !== exp_r.last) begin
               $error("last expected %0d actual %0d", exp_r.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset = 0;
      test_directed();
      test_full_table();
      test_random();
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (awaited_results.size() != 0) errors++;
      $display("Sent %0d transactions, checked %0d results with %0d timer firings.",
               items_sent, results_seen, fired_seen);
      $display("Slack was written %0d times, including both extremes and a full table.",
               slack_writes);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

[files.f]
sv/sts_pkg.sv
sv/sorted_software_timer_scheduler.sv
sim/testbench.sv
